// ===== design/rmst_pkg.sv =====
// Shared types and constants for the range-maximum segment tree.
package rmst_pkg;

	localparam int unsigned POS_W = 11;
	localparam int unsigned VAL_W = 32;

	// Result of a query whose interval holds no position.
	localparam logic signed [VAL_W-1:0] EMPTY_MAX = -32'sd1000000000;

	typedef enum logic {
		CMD_WRITE = 1'b0,
		CMD_QUERY = 1'b1
	} cmd_t;

	typedef struct packed {
		cmd_t                     cmd;
		logic [POS_W-1:0]         position;
		logic signed [VAL_W-1:0]  value;
		logic [POS_W-1:0]         range_left;
		logic [POS_W-1:0]         range_right;
	} req_t;

	typedef struct packed {
		logic signed [VAL_W-1:0]  max_value;
	} rsp_t;

endpackage

// ===== design/rmst_stream_if.sv =====
// Valid/ready stream channel carrying one payload per request.
interface rmst_stream_if #(
	parameter type payload_t = logic
) ();
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

// ===== design/range_max_segment_tree.sv =====
// Range-maximum segment tree over LEAVES signed values with point writes and range queries.
//
// The tree nodes live in one memory of 2*SPAN words (SPAN = LEAVES rounded up to a power of
// two) with one write port and one registered read port. After reset the block runs a clearing
// pass, one node per cycle, before it takes its first request. Every request is accepted in
// idle. After that, a point write keeps the block busy while the leaf is written and then each
// level reads the sibling and writes the parent maximum. A write to a position outside
// 1..LEAVES is dropped in its accept cycle. A range query reads at most two nodes per level
// through the single read port, so it keeps the block busy over its reads, and longer while
// the previous result still waits in the output register. Writes give no result; each query
// gives exactly one.
module range_max_segment_tree #(
	parameter int unsigned LEAVES = 1024
) (
	input  logic                  clk,
	input  logic                  arst_n,
	rmst_stream_if.sink           req,
	rmst_stream_if.source         rsp
);

	localparam int unsigned SPAN  = 1 << $clog2(LEAVES);
	localparam int unsigned NW    = $clog2(SPAN) + 1;          // node index bits
	localparam int unsigned DEPTH = 2 * SPAN;
	localparam int unsigned AW    = NW + 1;                    // interval bound bits
	localparam int unsigned CW    = (AW > rmst_pkg::POS_W + 1) ? AW : rmst_pkg::POS_W + 1;
	localparam int unsigned VW    = rmst_pkg::VAL_W;

	localparam logic [NW-1:0] ROOT     = NW'(1);
	localparam logic [CW-1:0] ONE_C    = CW'(1);
	localparam logic [CW-1:0] SPAN_C   = CW'(SPAN);
	localparam logic [CW-1:0] HI_LIM_C = CW'(SPAN + 1);
	localparam logic [CW-1:0] LEAVES_C = CW'(LEAVES);

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_LEAF,
		S_CLIMB,
		S_QLEFT,
		S_QRIGHT,
		S_QFIN
	} state_t;

	state_t                 state_q;
	logic [NW-1:0]          clr_q;
	logic [NW-1:0]          node_q;
	logic signed [VW-1:0]   cur_q;
	logic [AW-1:0]          a_q;
	logic [AW-1:0]          b_q;
	logic signed [VW-1:0]   best_q;
	logic                   any_q;
	logic                   rd_pend_q;
	logic                   rsp_valid_q;
	logic signed [VW-1:0]   rsp_data_q;

	// Node memory.
	logic signed [VW-1:0]   mem [DEPTH];
	logic signed [VW-1:0]   mem_rdata_q;
	logic                   mem_we;
	logic [NW-1:0]          mem_waddr;
	logic signed [VW-1:0]   mem_wdata;
	logic                   mem_re;
	logic [NW-1:0]          mem_raddr;

	always_ff @(posedge clk) begin
		if (mem_we)
			mem[mem_waddr] <= mem_wdata;
		if (mem_re)
			mem_rdata_q <= mem[mem_raddr];
	end

	// Request decode.
	logic [CW-1:0]          pos_c, lo_c, hi_c, lo_clip, hi_clip;
	logic                   pos_ok;
	logic [NW-1:0]          leaf_node;
	logic [CW-1:0]          a_init, b_init;
	logic                   accept;

	assign accept = req.valid && req.ready;

	always_comb begin
		pos_c     = {{(CW-rmst_pkg::POS_W){1'b0}}, req.data.position};
		lo_c      = {{(CW-rmst_pkg::POS_W){1'b0}}, req.data.range_left};
		hi_c      = {{(CW-rmst_pkg::POS_W){1'b0}}, req.data.range_right};
		pos_ok    = (pos_c >= ONE_C) && (pos_c <= LEAVES_C);
		leaf_node = NW'(pos_c + SPAN_C - ONE_C);
		lo_clip   = (lo_c < ONE_C) ? ONE_C : lo_c;
		hi_clip   = (hi_c > HI_LIM_C) ? HI_LIM_C : hi_c;
		a_init    = lo_clip + SPAN_C - ONE_C;
		b_init    = hi_clip + SPAN_C - ONE_C;
	end

	// Climb step: new parent value from the current node and its sibling; query read address and running maximum.
	logic [NW-1:0]          parent;
	logic signed [VW-1:0]   climb_max;
	logic [AW-1:0]          b_m1;
	logic signed [VW-1:0]   acc_max;

	assign parent    = {1'b0, node_q[NW-1:1]};
	assign climb_max = (cur_q > mem_rdata_q) ? cur_q : mem_rdata_q;
	assign b_m1      = b_q - AW'(1);
	assign acc_max   = (best_q > mem_rdata_q) ? best_q : mem_rdata_q;

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = '0;
		mem_wdata = '0;
		mem_re    = 1'b0;
		mem_raddr = '0;
		unique case (state_q)
			S_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_q;
			end
			S_LEAF: begin
				mem_we    = 1'b1;
				mem_waddr = node_q;
				mem_wdata = cur_q;
				mem_re    = 1'b1;
				mem_raddr = {node_q[NW-1:1], ~node_q[0]};
			end
			S_CLIMB: begin
				mem_we    = 1'b1;
				mem_waddr = parent;
				mem_wdata = climb_max;
				mem_re    = (parent != ROOT);
				mem_raddr = {parent[NW-1:1], ~parent[0]};
			end
			S_QLEFT: begin
				mem_re    = (a_q < b_q) && a_q[0];
				mem_raddr = a_q[NW-1:0];
			end
			S_QRIGHT: begin
				mem_re    = b_q[0];
				mem_raddr = b_m1[NW-1:0];
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_q       <= '0;
			rd_pend_q   <= 1'b0;
			any_q       <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			// A query read issued last cycle folds into the running maximum now.
			rd_pend_q <= (state_q == S_QLEFT || state_q == S_QRIGHT) && mem_re;
			if (rd_pend_q) begin
				best_q <= any_q ? acc_max : mem_rdata_q;
				any_q  <= 1'b1;
			end
			if (rsp_valid_q && rsp.ready)
				rsp_valid_q <= 1'b0;

			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + NW'(1);
					if (clr_q == NW'(DEPTH - 1))
						state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (accept) begin
						if (req.data.cmd == rmst_pkg::CMD_WRITE) begin
							node_q <= leaf_node;
							cur_q  <= req.data.value;
							if (pos_ok)
								state_q <= S_LEAF;
						end else begin
							any_q <= 1'b0;
							a_q   <= a_init[AW-1:0];
							b_q   <= b_init[AW-1:0];
							state_q <= (lo_clip >= hi_clip) ? S_QFIN : S_QLEFT;
						end
					end
				end
				S_LEAF: begin
					state_q <= S_CLIMB;
				end
				S_CLIMB: begin
					cur_q  <= climb_max;
					node_q <= parent;
					if (parent == ROOT)
						state_q <= S_IDLE;
				end
				S_QLEFT: begin
					if (a_q >= b_q) begin
						state_q <= S_QFIN;
					end else begin
						if (a_q[0])
							a_q <= a_q + AW'(1);
						state_q <= S_QRIGHT;
					end
				end
				S_QRIGHT: begin
					a_q     <= a_q >> 1;
					b_q     <= b_q >> 1;
					state_q <= S_QLEFT;
				end
				S_QFIN: begin
					if (!rsp_valid_q || rsp.ready) begin
						rsp_valid_q <= 1'b1;
						rsp_data_q  <= any_q ? best_q : rmst_pkg::EMPTY_MAX;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign req.ready          = (state_q == S_IDLE);
	assign rsp.valid          = rsp_valid_q;
	assign rsp.data.max_value = rsp_data_q;

	// The memory is never read and written at the same node in one cycle.
	a_no_rw_clash: assert property (@(posedge clk) disable iff (!arst_n)
		(mem_we && mem_re) |-> (mem_waddr != mem_raddr))
		else $error("node memory read and write collide");

	// The climb never walks above the root.
	a_climb_below_root: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CLIMB) |-> (node_q >= NW'(2)))
		else $error("climb reached an invalid node");

	// One request at a time: a query or an in-range write keeps the block busy.
	a_busy_after_req: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready && (req.data.cmd == rmst_pkg::CMD_QUERY || pos_ok))
		|=> !req.ready)
		else $error("request accepted while busy");

endmodule

// ===== tb/sv/rmst_max_checker.sv =====
`timescale 1ns / 100ps
// Request and result monitor that predicts each range maximum and compares it with the block.
module rmst_max_checker #(
	parameter int unsigned LEAVES = 1024
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	input  logic             req_ready,
	input  rmst_pkg::req_t   req_data,
	input  logic             rsp_valid,
	input  logic             rsp_ready,
	input  rmst_pkg::rsp_t   rsp_data,
	output int unsigned      mismatches,
	output int unsigned      outstanding,
	output int unsigned      writes_seen,
	output int unsigned      queries_seen
);

	// Leaves past LEAVES up to the next power of two are padding that always reads zero.
	localparam int unsigned SPAN = 1 << $clog2(LEAVES);

	logic signed [rmst_pkg::VAL_W-1:0] leaf_val [1:SPAN];
	logic signed [rmst_pkg::VAL_W-1:0] expected_max_q [$];
	logic signed [rmst_pkg::VAL_W-1:0] predicted;
	int unsigned                       fail_total;
	int unsigned                       write_total;
	int unsigned                       query_total;

	task automatic report_mismatch(input string msg);
		fail_total++;
		$display("[%0t] MISMATCH: %s", $realtime, msg);
	endtask

	function automatic void store_point(input logic [rmst_pkg::POS_W-1:0] pos,
			input logic signed [rmst_pkg::VAL_W-1:0] v);
		if (pos < 1 || pos > LEAVES)
			return;
		leaf_val[pos] = v;
	endfunction

	// The interval is clipped to the leaf span; padding leaves inside it count as zero.
	function automatic logic signed [rmst_pkg::VAL_W-1:0] interval_max(
			input logic [rmst_pkg::POS_W-1:0] left,
			input logic [rmst_pkg::POS_W-1:0] right);
		int unsigned                       lo;
		int unsigned                       hi;
		logic signed [rmst_pkg::VAL_W-1:0] best;
		lo = (left < 1) ? 1 : left;
		hi = (right > SPAN + 1) ? SPAN + 1 : right;
		if (lo >= hi)
			return rmst_pkg::EMPTY_MAX;
		best = leaf_val[lo];
		for (int unsigned p = lo + 1; p < hi; p++) begin
			if (leaf_val[p] > best)
				best = leaf_val[p];
		end
		return best;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			foreach (leaf_val[p])
				leaf_val[p] = '0;
			expected_max_q.delete();
			fail_total = 0;
			write_total = 0;
			query_total = 0;
			mismatches <= 0;
			outstanding <= 0;
			writes_seen <= 0;
			queries_seen <= 0;
		end else begin
			// A result always belongs to a query accepted at an earlier edge.
			if (rsp_valid && rsp_ready) begin
				if (expected_max_q.size() == 0) begin
					report_mismatch($sformatf("result %0d arrived with no query waiting",
						rsp_data.max_value));
				end else begin
					predicted = expected_max_q.pop_front();
					query_total++;
					if (rsp_data.max_value !== predicted)
						report_mismatch($sformatf("max_value %0d, predicted %0d",
							rsp_data.max_value, predicted));
				end
			end
			if (req_valid && req_ready) begin
				if (req_data.cmd == rmst_pkg::CMD_WRITE) begin
					store_point(req_data.position, req_data.value);
					write_total++;
				end else begin
					expected_max_q.push_back(interval_max(req_data.range_left,
						req_data.range_right));
				end
			end
			mismatches <= fail_total;
			outstanding <= expected_max_q.size();
			writes_seen <= write_total;
			queries_seen <= query_total;
		end
	end

endmodule

// ===== tb/sv/tb_range_max_segment_tree.sv =====
`timescale 1ns / 100ps
// Top of the segment tree bench: clock, reset, request stimulus, flow control and verdict.
module tb_range_max_segment_tree;

	localparam int unsigned LEAVES          = 1024;
	localparam int unsigned CYCLE_LIMIT     = 400000;
	localparam int unsigned HOLD_CYCLES     = 600;
	localparam int unsigned DRAIN_CYCLES    = 64;
	localparam int unsigned ITEMS_PER_PHASE = 150;

	typedef enum {
		PH_CALM,
		PH_SENDER_GAPS,
		PH_RECEIVER_STALLS,
		PH_BOTH,
		PH_BACKPRESSURE
	} phase_t;

	logic        clk;
	logic        arst_n;
	logic        hold_go;
	logic        hold_rx;
	int unsigned send_idle_pct;
	int unsigned stall_pct;
	int unsigned cycle_count;
	int unsigned mismatches;
	int unsigned outstanding;
	int unsigned writes_seen;
	int unsigned queries_seen;

	rmst_stream_if #(.payload_t(rmst_pkg::req_t)) req_ch ();
	rmst_stream_if #(.payload_t(rmst_pkg::rsp_t)) rsp_ch ();

	range_max_segment_tree #(.LEAVES(LEAVES)) DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	rmst_max_checker #(.LEAVES(LEAVES)) u_max_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.req_valid    (req_ch.valid),
		.req_ready    (req_ch.ready),
		.req_data     (req_ch.data),
		.rsp_valid    (rsp_ch.valid),
		.rsp_ready    (rsp_ch.ready),
		.rsp_data     (rsp_ch.data),
		.mismatches   (mismatches),
		.outstanding  (outstanding),
		.writes_seen  (writes_seen),
		.queries_seen (queries_seen)
	);

	initial clk = 1'b0;
	always #10 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Timed out after %0d cycles, %0d results still due", cycle_count,
				outstanding);
			$display("range_max_segment_tree: mismatch");
			$finish;
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
		end else begin
			rsp_ch.ready <= !hold_rx && ($urandom_range(99) >= stall_pct);
		end
	end

	// Long output hold-off so the block fills up and pushes back on requests.
	initial begin
		hold_rx = 1'b0;
		wait (hold_go);
		@(posedge clk);
		hold_rx <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		hold_rx <= 1'b0;
	end

	task automatic send_req(input rmst_pkg::req_t item);
		while ($urandom_range(99) < send_idle_pct) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.data <= item;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
	endtask

	// Random filler for a field that the request ignores.
	function automatic logic [rmst_pkg::POS_W-1:0] rand_field();
		int unsigned x;
		x = $urandom_range(2047);
		return x[rmst_pkg::POS_W-1:0];
	endfunction

	function automatic rmst_pkg::req_t write_req(input int unsigned pos,
			input logic [rmst_pkg::VAL_W-1:0] v);
		rmst_pkg::req_t r;
		r.cmd = rmst_pkg::CMD_WRITE;
		r.position = pos[rmst_pkg::POS_W-1:0];
		r.value = v;
		r.range_left = rand_field();
		r.range_right = rand_field();
		return r;
	endfunction

	function automatic rmst_pkg::req_t query_req(input int unsigned left,
			input int unsigned right);
		rmst_pkg::req_t r;
		r.cmd = rmst_pkg::CMD_QUERY;
		r.position = rand_field();
		r.value = $urandom;
		r.range_left = left[rmst_pkg::POS_W-1:0];
		r.range_right = right[rmst_pkg::POS_W-1:0];
		return r;
	endfunction

	// Positions near both ends of the tree, where writes and queries are concentrated.
	function automatic int unsigned hot_pos();
		return ($urandom_range(1)) ? $urandom_range(16, 1) : $urandom_range(LEAVES, LEAVES - 15);
	endfunction

	function automatic rmst_pkg::req_t random_req();
		int unsigned pick;
		int unsigned lo;
		int unsigned pos;
		logic [rmst_pkg::VAL_W-1:0] v;
		if ($urandom_range(1)) begin
			pick = $urandom_range(99);
			if (pick < 15)
				pos = ($urandom_range(3) == 0) ? 0 : $urandom_range(2047, LEAVES + 1);
			else if (pick < 55)
				pos = hot_pos();
			else
				pos = $urandom_range(LEAVES, 1);
			pick = $urandom_range(99);
			if (pick < 45)
				v = 0 - $urandom_range(5000, 1);
			else if (pick < 55)
				case ($urandom_range(3))
					0: v = 32'h7fff_ffff;
					1: v = 32'h8000_0000;
					2: v = 32'h0000_0000;
					default: v = 32'hffff_ffff;
				endcase
			else
				v = $urandom;
			return write_req(pos, v);
		end
		pick = $urandom_range(99);
		if (pick < 30) begin
			lo = hot_pos();
			return query_req(lo, lo + $urandom_range(12));
		end else if (pick < 50) begin
			lo = $urandom_range(LEAVES, 1);
			return query_req(lo, lo + $urandom_range(40));
		end else if (pick < 62) begin
			return query_req($urandom_range(16), $urandom_range(LEAVES + 1, LEAVES - 15));
		end else if (pick < 75) begin
			lo = $urandom_range(2047, 1);
			return query_req(lo, $urandom_range(lo, 0));
		end
		return query_req($urandom_range(2047), $urandom_range(2047));
	endfunction

	task automatic run_directed();
		send_req(query_req(1, LEAVES + 1));
		send_req(query_req(0, 2047));
		send_req(query_req(5, 5));
		send_req(query_req(9, 3));
		send_req(query_req(0, 1));
		send_req(query_req(LEAVES + 1, 2047));
		send_req(write_req(1, 32'h7fff_ffff));
		send_req(write_req(LEAVES, 32'h8000_0000));
		// Writes outside the positions must leave the tree untouched.
		send_req(write_req(0, 32'd12345));
		send_req(write_req(LEAVES + 1, 32'd777));
		send_req(write_req(2047, 32'hffff_ffff));
		send_req(write_req(512, -32'sd5));
		send_req(query_req(1, 2));
		send_req(query_req(LEAVES, LEAVES + 1));
		send_req(query_req(512, 513));
		send_req(query_req(2, LEAVES));
		send_req(query_req(0, 2047));
		send_req(query_req(LEAVES, 2047));
		send_req(write_req(1, -32'sd7));
		send_req(write_req(2, -32'sd9));
		send_req(query_req(1, 3));
		send_req(query_req(0, 3));
		send_req(query_req(1, 1));
	endtask

	initial begin
		phase_t plan [5];
		plan = '{PH_CALM, PH_SENDER_GAPS, PH_RECEIVER_STALLS, PH_BOTH, PH_BACKPRESSURE};
		arst_n = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.data = '0;
		hold_go = 1'b0;
		send_idle_pct = 0;
		stall_pct = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		send_idle_pct = 18;
		stall_pct <= 18;
		run_directed();

		foreach (plan[i]) begin
			case (plan[i])
				PH_CALM: begin
					send_idle_pct = 0;
					stall_pct <= 0;
				end
				PH_SENDER_GAPS: begin
					send_idle_pct = 72;
					stall_pct <= 0;
				end
				PH_RECEIVER_STALLS: begin
					send_idle_pct = 0;
					stall_pct <= 72;
				end
				PH_BOTH: begin
					send_idle_pct = 18;
					stall_pct <= 18;
				end
				default: begin
					send_idle_pct = 0;
					stall_pct <= 0;
					hold_go = 1'b1;
				end
			endcase
			repeat (ITEMS_PER_PHASE)
				send_req(random_req());
		end
		req_ch.valid <= 1'b0;

		do
			@(posedge clk);
		while (outstanding != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Run covered %0d point writes and %0d checked range queries", writes_seen,
			queries_seen);
		$display("under free flow, sender gaps, output stalls and a %0d-cycle output hold-off.",
			HOLD_CYCLES);
		if (mismatches == 0 && outstanding == 0) begin
			$display("range_max_segment_tree: match");
		end else begin
			$display("range_max_segment_tree: mismatch");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
design/rmst_pkg.sv
design/rmst_stream_if.sv
design/range_max_segment_tree.sv
tb/sv/rmst_max_checker.sv
tb/sv/tb_range_max_segment_tree.sv
